// File: rtl/core/abump_pkg.sv
// Shared types and constants for the arena bump allocator.
// No dependencies; abump_calc, arena_bump_allocator and the testbench import this package.
package abump_pkg;

  localparam int unsigned ALIGN        = 8;
  localparam int unsigned COMMIT_BLOCK = 4096;

  localparam logic [32:0] AlignLow33  = 33'(ALIGN - 1);
  localparam logic [31:0] AlignLow32  = 32'(ALIGN - 1);
  localparam logic [32:0] CommitLow33 = 33'(COMMIT_BLOCK - 1);
  localparam logic [32:0] CommitSize  = 33'(COMMIT_BLOCK);
  localparam logic [32:0] CommitMax   = '1;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_POP_SIZE = 2'd1,
    ACT_POP_TO   = 2'd2,
    ACT_RESET    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MREQ_NONE      = 2'd0,
    MREQ_COMMIT    = 2'd1,
    MREQ_DECOMMIT  = 2'd2,
    MREQ_RELEASE   = 2'd3
  } mem_req_e;

  typedef struct packed {
    logic [31:0] top;
    logic [32:0] committed;
  } arena_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] block_offset;
    mem_req_e    mem_request;
    logic [32:0] request_offset;
    logic [32:0] request_size;
  } result_t;

endpackage

// File: rtl/core/abump_if.sv
// Valid/ready channel interfaces for requests, results and the capacity register.
// Self-contained; the payload widths match the types in abump_pkg.
interface abump_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] amount;

  modport source (output valid, action, amount, input ready);
  modport sink (input valid, action, amount, output ready);
endinterface

interface abump_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] block_offset;
  logic [1:0]  mem_request;
  logic [32:0] request_offset;
  logic [32:0] request_size;

  modport source (output valid, ok, block_offset, mem_request, request_offset,
                  request_size, input ready);
  modport sink (input valid, ok, block_offset, mem_request, request_offset,
                request_size, output ready);
endinterface

interface abump_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface

// File: rtl/core/abump_calc.sv
// Next-state and result logic for one allocator request.
// Depends on abump_pkg; purely combinational.
module abump_calc (
  input  abump_pkg::action_e      action_i,
  input  logic [31:0]             amount_i,
  input  logic [31:0]             capacity_i,
  input  abump_pkg::arena_state_t state_i,
  output abump_pkg::arena_state_t state_o,
  output abump_pkg::result_t      result_o
);
  import abump_pkg::*;

  logic [32:0] size;
  logic [33:0] alloc_end;
  logic [32:0] csize;
  logic [33:0] commit_sum;
  logic [31:0] pop_top;
  logic [31:0] target;
  logic [32:0] spare_bytes;
  logic [32:0] rem;
  logic [32:0] trim_offset;
  logic        trim_hit;

  assign size       = ({1'b0, amount_i} + AlignLow33) & ~AlignLow33;
  assign alloc_end  = {2'b00, state_i.top} + {1'b0, size};
  assign csize      = (size + CommitLow33) & ~CommitLow33;
  assign commit_sum = {1'b0, state_i.committed} + {1'b0, csize};
  assign target     = amount_i & ~AlignLow32;

  always_comb begin
    if (action_i == ACT_POP_SIZE) begin
      pop_top = (size >= {1'b0, state_i.top}) ? '0 : state_i.top - size[31:0];
    end else begin
      pop_top = target;
    end
  end

  assign spare_bytes = state_i.committed - {1'b0, pop_top};
  assign rem         = spare_bytes & CommitLow33;
  assign trim_offset = {1'b0, pop_top} + rem;
  assign trim_hit    = (state_i.committed >= {1'b0, pop_top}) &&
                       (spare_bytes >= CommitSize);

  always_comb begin
    state_o  = state_i;
    result_o = '{ok: 1'b1, block_offset: '0, mem_request: MREQ_NONE,
                 request_offset: '0, request_size: '0};
    unique case (action_i) inside
      ACT_ALLOC: begin
        if (alloc_end > {2'b00, capacity_i}) begin
          result_o.ok = 1'b0;
        end else begin
          if (alloc_end > {1'b0, state_i.committed}) begin
            result_o.mem_request    = MREQ_COMMIT;
            result_o.request_offset = state_i.committed;
            result_o.request_size   = csize;
            state_o.committed       = commit_sum[33] ? CommitMax : commit_sum[32:0];
          end
          result_o.block_offset = state_i.top;
          state_o.top           = alloc_end[31:0];
        end
      end
      ACT_POP_SIZE, ACT_POP_TO: begin
        if (action_i == ACT_POP_SIZE || amount_i < state_i.top) begin
          state_o.top = pop_top;
          if (trim_hit) begin
            result_o.mem_request    = MREQ_DECOMMIT;
            result_o.request_offset = trim_offset;
            result_o.request_size   = spare_bytes & ~CommitLow33;
            state_o.committed       = trim_offset;
          end
        end
      end
      ACT_RESET: begin
        result_o.mem_request  = MREQ_RELEASE;
        result_o.request_size = state_i.committed;
        state_o               = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// File: rtl/core/arena_bump_allocator.sv
// Arena bump allocator: a request is taken in the cycle it is offered while the result
// register is empty or being drained, so one request per cycle is sustained; its result
// is registered and appears in the following cycle. The throughput is set by the single pass through abump_calc,
// which updates the top and committed registers in the accepting cycle. The capacity
// register is always ready and should be written only while the block is idle.
// Depends on abump_pkg, abump_if.sv and abump_calc.
module arena_bump_allocator (
  input logic         clk_i,
  input logic         rst_ni,
  abump_req_if.sink   req,
  abump_rsp_if.source rsp,
  abump_cfg_if.sink   cfg
);
  import abump_pkg::*;

  arena_state_t state_q, state_d;
  result_t      result_q, result_d;
  logic         rsp_valid_q;
  logic [31:0]  capacity_q;
  logic         req_fire;

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  abump_calc u_calc (
    .action_i  (action_e'(req.action)),
    .amount_i  (req.amount),
    .capacity_i(capacity_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      rsp_valid_q <= 1'b0;
      capacity_q  <= '1;
    end else begin
      if (cfg.valid) begin
        capacity_q <= cfg.capacity;
      end
      if (req_fire) begin
        state_q     <= state_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      result_q <= result_d;
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.ok             = result_q.ok;
  assign rsp.block_offset   = result_q.block_offset;
  assign rsp.mem_request    = result_q.mem_request;
  assign rsp.request_offset = result_q.request_offset;
  assign rsp.request_size   = result_q.request_size;

  // The committed mark never falls below the top of the arena.
  a_commit_covers_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.committed >= {1'b0, state_q.top})
    else $error("committed mark below top");

  // A reset request empties the arena.
  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req.action == ACT_RESET |=> state_q == '0)
    else $error("reset request left state behind");

  // A pop by size leaves less than one commit block of free committed space.
  a_pop_trims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req.action == ACT_POP_SIZE
    |=> (state_q.committed - {1'b0, state_q.top}) < CommitSize)
    else $error("pop left a whole free block committed");

  // A failed allocation carries no memory request and no block.
  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !result_q.ok
    |-> result_q.mem_request == MREQ_NONE && result_q.block_offset == '0)
    else $error("failed allocation produced a request");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for arena_bump_allocator: drives request beats, predicts each
// result from a model of the top and committed marks, and checks every result beat.
// Depends on abump_pkg and the abump_req_if, abump_rsp_if and abump_cfg_if interfaces.
module testbench;
  import abump_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst_n;

  abump_req_if req_bus ();
  abump_rsp_if rsp_bus ();
  abump_cfg_if cfg_bus ();

  arena_bump_allocator dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req   (req_bus),
    .rsp   (rsp_bus),
    .cfg   (cfg_bus)
  );

  longint unsigned arena_top;
  longint unsigned arena_committed;
  longint unsigned arena_capacity;
  result_t         expected_results[$];
  int              errors = 0;
  int              idle_cycles = 0;
  int              burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned round_up(longint unsigned v, longint unsigned a);
    return (v % a != 0) ? v + a - v % a : v;
  endfunction

  function automatic void trim_free_blocks(inout result_t r);
    longint unsigned spare;
    longint unsigned part;
    if (arena_committed < arena_top) return;
    spare = arena_committed - arena_top;
    if (spare < COMMIT_BLOCK) return;
    part = spare % COMMIT_BLOCK;
    r.mem_request    = MREQ_DECOMMIT;
    r.request_offset = 33'(arena_top + part);
    r.request_size   = 33'(spare - part);
    arena_committed  = arena_committed - (spare - part);
  endfunction

  function automatic result_t predict_arena(action_e act, logic [31:0] amt);
    result_t         r;
    longint unsigned a;
    longint unsigned sz;
    longint unsigned fin;
    longint unsigned csz;
    a = 64'(amt);
    r = '0;
    r.ok = 1'b1;
    r.mem_request = MREQ_NONE;
    case (act)
      ACT_ALLOC: begin
        sz  = round_up(a, ALIGN);
        fin = arena_top + sz;
        if (fin > arena_capacity) begin
          r.ok = 1'b0;
        end else begin
          if (fin > arena_committed) begin
            csz = round_up(sz, COMMIT_BLOCK);
            r.mem_request    = MREQ_COMMIT;
            r.request_offset = 33'(arena_committed);
            r.request_size   = 33'(csz);
            arena_committed  = arena_committed + csz;
            if (arena_committed > 64'h1_FFFF_FFFF) arena_committed = 64'h1_FFFF_FFFF;
          end
          r.block_offset = 32'(arena_top);
          arena_top = fin;
        end
      end
      ACT_POP_SIZE: begin
        sz = round_up(a, ALIGN);
        if (sz >= arena_top) arena_top = 0;
        else arena_top = arena_top - sz;
        trim_free_blocks(r);
      end
      ACT_POP_TO: begin
        if (a < arena_top) begin
          arena_top = a - a % ALIGN;
          trim_free_blocks(r);
        end
      end
      default: begin
        r.mem_request   = MREQ_RELEASE;
        r.request_size  = 33'(arena_committed);
        arena_top       = 0;
        arena_committed = 0;
      end
    endcase
    return r;
  endfunction

  task automatic send_req(action_e act, logic [31:0] amt);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
    end
    burst_left--;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid  <= 1'b1;
    req_bus.action <= act;
    req_bus.amount <= amt;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    expected_results.push_back(predict_arena(act, amt));
  endtask

  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    wait_for_results();
    cfg_bus.valid    <= 1'b1;
    cfg_bus.capacity <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid  <= 1'b0;
    arena_capacity = 64'(value);
  endtask

  function automatic logic [31:0] random_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) return $urandom_range(0, 9000);
    if (sel < 19) return $urandom_range(0, 300000);
    return $urandom;
  endfunction

  task automatic random_phase(logic [31:0] cap, int count);
    action_e     act;
    logic [31:0] amt;
    int          pick;
    write_capacity(cap);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        act = ACT_ALLOC;
        amt = random_size();
      end else if (pick < 70) begin
        act = ACT_POP_SIZE;
        amt = ($urandom_range(0, 9) < 7) ? random_size() : $urandom_range(0, 32'(arena_top));
      end else if (pick < 96) begin
        act = ACT_POP_TO;
        if ($urandom_range(0, 19) < 17)
          amt = (arena_top > 0) ? $urandom_range(0, 32'(arena_top) - 1) : 32'd0;
        else
          amt = $urandom;
      end else begin
        act = ACT_RESET;
        amt = $urandom;
      end
      send_req(act, amt);
      if (i == count / 2) wait_for_results();
    end
    wait_for_results();
  endtask

  task automatic test_request_edges();
    send_req(ACT_ALLOC, 32'd0);
    send_req(ACT_ALLOC, 32'd1);
    send_req(ACT_ALLOC, 32'd8);
    send_req(ACT_ALLOC, 32'd4095);
    send_req(ACT_ALLOC, 32'd4096);
    send_req(ACT_POP_TO, 32'(arena_top));
    send_req(ACT_POP_TO, 32'hFFFF_FFFF);
    send_req(ACT_POP_TO, 32'd13);
    send_req(ACT_POP_SIZE, 32'd0);
    send_req(ACT_POP_SIZE, 32'd3);
    send_req(ACT_POP_SIZE, 32'hFFFF_FFFF);
    send_req(ACT_RESET, 32'd0);
    send_req(ACT_ALLOC, 32'hFFFF_FFFF);
    send_req(ACT_ALLOC, 32'hFFFF_FFF8);
    send_req(ACT_ALLOC, 32'd0);
    send_req(ACT_ALLOC, 32'd8);
    send_req(ACT_POP_TO, 32'h1234_5677);
    send_req(ACT_POP_SIZE, 32'h0000_1000);
    send_req(ACT_RESET, 32'hFFFF_FFFF);
    send_req(ACT_POP_TO, 32'd0);
    send_req(ACT_POP_SIZE, 32'd5);
    wait_for_results();
  endtask

  task automatic test_capacity_edges();
    write_capacity(32'd0);
    send_req(ACT_ALLOC, 32'd0);
    send_req(ACT_ALLOC, 32'd1);
    send_req(ACT_POP_SIZE, 32'd0);
    write_capacity(32'd24);
    send_req(ACT_ALLOC, 32'd17);
    send_req(ACT_ALLOC, 32'd1);
    send_req(ACT_ALLOC, 32'd0);
    send_req(ACT_POP_TO, 32'd7);
    send_req(ACT_RESET, 32'd0);
    write_capacity(32'hFFFF_FFFF);
    send_req(ACT_ALLOC, 32'hFFFF_FFF7);
    send_req(ACT_ALLOC, 32'd7);
    send_req(ACT_RESET, 32'd0);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    random_phase(32'hFFFF_FFFF, 240);
    random_phase($urandom_range(4096, 65536), 240);
    random_phase($urandom, 240);
    random_phase(32'd0, 50);
    random_phase($urandom_range(100000, 2000000), 240);
  endtask

  // The receiver drops ready on the zero bits of a rotating 16-bit mask, redrawn when its age counter runs out.
  initial begin : sink_stall
    logic [15:0] pattern;
    int          age;
    pattern = '1;
    age     = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (age == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        age     = 64;
      end
      age--;
      rsp_bus.ready <= pattern[0];
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  task automatic check_field(string name, logic [32:0] want, logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rsp_bus.valid && rsp_bus.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no request pending", $time);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("ok", 33'(want.ok), 33'(rsp_bus.ok));
        check_field("block_offset", 33'(want.block_offset), 33'(rsp_bus.block_offset));
        check_field("mem_request", 33'(want.mem_request), 33'(rsp_bus.mem_request));
        check_field("request_offset", want.request_offset, rsp_bus.request_offset);
        check_field("request_size", want.request_size, rsp_bus.request_size);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.action   <= ACT_ALLOC;
    req_bus.amount   <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.capacity <= '0;
    arena_top       = 0;
    arena_committed = 0;
    arena_capacity  = 64'hFFFF_FFFF;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_request_edges();
    test_capacity_edges();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
